// ----- sv/recursive_lock_with_wait_queue_unit_defines.svh -----
// Assertion macros shared by the checker of the recursive lock unit.
`ifndef RECURSIVE_LOCK_WITH_WAIT_QUEUE_UNIT_DEFINES_SVH
`define RECURSIVE_LOCK_WITH_WAIT_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define RLWQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rlwq same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define RLWQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rlwq next-cycle check failed");

`endif

// ----- sv/rlwq_pkg.sv -----
// Shared types and constants of the recursive lock unit.
package rlwq_pkg;

    // Beat widths on the two stream channels.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;

    // Field widths fixed by the item format.
    localparam int OP_W     = 1;
    localparam int TID_W    = 4;
    localparam int STATUS_W = 3;
    localparam int HOLD_W   = 8;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ACQUIRE = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_GRANTED    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_HOLDER = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUP_WAIT   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW   = 3'd6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming request beat
        logic execute;   // apply the request and load the result register
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_stall; // result register full and not being taken
    } t_dp_status;

endpackage

// ----- sv/rlwq_ctrl.sv -----
// Controller state machine: sequences request capture and execution.
module rlwq_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  rlwq_pkg::t_dp_status  i_status,
    output rlwq_pkg::t_ctrl_cmd   o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_status.out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands decoded from the state.
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.execute = (r_state == S_EXEC) && !i_status.out_stall;

endmodule

// ----- sv/rlwq_dp.sv -----
// Datapath: lock owner and count, wait queue memory, waiter bitmap, result register.
module rlwq_dp #(
    parameter int THREAD_COUNT = 16,
    parameter int QUEUE_DEPTH  = 16,
    parameter int COUNT_BITS   = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rlwq_pkg::t_ctrl_cmd                  i_cmd,
    output rlwq_pkg::t_dp_status                 o_status,
    input  logic [rlwq_pkg::OP_W-1:0]            i_op,
    input  logic [rlwq_pkg::TID_W-1:0]           i_tid,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [rlwq_pkg::STATUS_W-1:0]        o_res_status,
    output logic                                 o_res_woken_valid,
    output logic [rlwq_pkg::TID_W-1:0]           o_res_woken_thread,
    output logic [rlwq_pkg::HOLD_W-1:0]          o_res_hold_count
);

    localparam int TIDX_W    = $clog2(THREAD_COUNT);
    localparam int TEXT_W    = 9;
    localparam int QIDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int CNT_EXT_W = (COUNT_BITS > rlwq_pkg::HOLD_W) ? COUNT_BITS : rlwq_pkg::HOLD_W;

    localparam logic [QIDX_W-1:0]     QLAST     = QIDX_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0]     QFULL     = FILL_W'(QUEUE_DEPTH);
    localparam logic [TEXT_W-1:0]     TLIMIT    = TEXT_W'(THREAD_COUNT);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Captured request.
    logic [rlwq_pkg::OP_W-1:0]  r_op;
    logic [rlwq_pkg::TID_W-1:0] r_tid;

    // Lock state.
    logic                    r_owner_valid, n_owner_valid;
    logic [rlwq_pkg::TID_W-1:0] r_owner, n_owner;
    logic [COUNT_BITS-1:0]   r_count, n_count;
    logic [QIDX_W-1:0]       r_head, n_head;
    logic [QIDX_W-1:0]       r_tail, n_tail;
    logic [FILL_W-1:0]       r_fill, n_fill;
    logic [THREAD_COUNT-1:0] r_map, n_map;

    // Wait queue memory and its registered head read.
    logic [rlwq_pkg::TID_W-1:0] mem_queue [QUEUE_DEPTH];
    logic [rlwq_pkg::TID_W-1:0] r_head_data;

    // Result register.
    logic                          r_out_valid;
    logic [rlwq_pkg::STATUS_W-1:0] r_res_status;
    logic                          r_res_wvalid;
    logic [rlwq_pkg::TID_W-1:0]    r_res_wthread;
    logic [rlwq_pkg::HOLD_W-1:0]   r_res_hold;

    // Combinational decision.
    logic [rlwq_pkg::STATUS_W-1:0] n_status;
    logic                          n_wvalid;
    logic [rlwq_pkg::TID_W-1:0]    n_wthread;
    logic                          push;
    logic [TEXT_W-1:0]             tid_ext;
    logic [TEXT_W-1:0]             woken_ext;
    logic [TIDX_W-1:0]             tid_idx;
    logic [TIDX_W-1:0]             woken_idx;
    logic                          tid_ok;
    logic                          woken_ok;
    logic                          is_owner;
    logic [CNT_EXT_W-1:0]          count_ext;

    assign tid_ext   = TEXT_W'(r_tid);
    assign woken_ext = TEXT_W'(r_head_data);
    assign tid_idx   = tid_ext[TIDX_W-1:0];
    assign woken_idx = woken_ext[TIDX_W-1:0];
    assign tid_ok    = (tid_ext < TLIMIT);
    assign woken_ok  = (woken_ext < TLIMIT);
    assign is_owner  = r_owner_valid && (r_owner == r_tid);

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_tid <= i_tid;
        end
    end

    // Decide the outcome of the captured request.
    always_comb begin
        n_owner_valid = r_owner_valid;
        n_owner       = r_owner;
        n_count       = r_count;
        n_head        = r_head;
        n_tail        = r_tail;
        n_fill        = r_fill;
        n_map         = r_map;
        n_status      = rlwq_pkg::ST_NOT_HOLDER;
        n_wvalid      = 1'b0;
        n_wthread     = '0;
        push          = 1'b0;
        priority if (!tid_ok) begin
            n_status = rlwq_pkg::ST_NOT_HOLDER;
        end else if (r_op == rlwq_pkg::OP_ACQUIRE) begin
            priority if (is_owner) begin
                if (r_count == COUNT_MAX) begin
                    n_status = rlwq_pkg::ST_OVERFLOW;
                end else begin
                    n_count  = COUNT_BITS'(r_count + 1'b1);
                    n_status = rlwq_pkg::ST_GRANTED;
                end
            end else if (r_map[tid_idx]) begin
                n_status = rlwq_pkg::ST_DUP_WAIT;
            end else if (!r_owner_valid) begin
                n_owner_valid = 1'b1;
                n_owner       = r_tid;
                n_count       = COUNT_BITS'(1);
                n_status      = rlwq_pkg::ST_GRANTED;
            end else if (r_fill == QFULL) begin
                n_status = rlwq_pkg::ST_FULL;
            end else begin
                push             = 1'b1;
                n_tail           = (r_tail == QLAST) ? '0 : QIDX_W'(r_tail + 1'b1);
                n_fill           = FILL_W'(r_fill + 1'b1);
                n_map[tid_idx]   = 1'b1;
                n_status         = rlwq_pkg::ST_QUEUED;
            end
        end else begin
            priority if (!is_owner) begin
                n_status = rlwq_pkg::ST_NOT_HOLDER;
            end else if (r_count <= COUNT_BITS'(1)) begin
                // Final release frees the lock and wakes the head waiter.
                n_count       = '0;
                n_owner_valid = 1'b0;
                n_owner       = '0;
                n_status      = rlwq_pkg::ST_RELEASED;
                if (r_fill != '0) begin
                    n_wvalid  = 1'b1;
                    n_wthread = r_head_data;
                    n_head    = (r_head == QLAST) ? '0 : QIDX_W'(r_head + 1'b1);
                    n_fill    = FILL_W'(r_fill - 1'b1);
                    if (woken_ok) begin
                        n_map[woken_idx] = 1'b0;
                    end
                end
            end else begin
                n_count  = COUNT_BITS'(r_count - 1'b1);
                n_status = rlwq_pkg::ST_RELEASED;
            end
        end
    end

    assign count_ext = CNT_EXT_W'(n_count);

    // Lock state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owner_valid <= 1'b0;
            r_owner       <= '0;
            r_count       <= '0;
            r_head        <= '0;
            r_tail        <= '0;
            r_fill        <= '0;
            r_map         <= '0;
        end else if (i_cmd.execute) begin
            r_owner_valid <= n_owner_valid;
            r_owner       <= n_owner;
            r_count       <= n_count;
            r_head        <= n_head;
            r_tail        <= n_tail;
            r_fill        <= n_fill;
            r_map         <= n_map;
        end
    end

    // Wait queue: push at the tail, head entry read every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && push) begin
            mem_queue[r_tail] <= r_tid;
        end
        r_head_data <= mem_queue[r_head];
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.execute) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_res_status  <= n_status;
            r_res_wvalid  <= n_wvalid;
            r_res_wthread <= n_wthread;
            r_res_hold    <= count_ext[rlwq_pkg::HOLD_W-1:0];
        end
    end

    assign o_status.out_stall = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_res_status       = r_res_status;
    assign o_res_woken_valid  = r_res_wvalid;
    assign o_res_woken_thread = r_res_wthread;
    assign o_res_hold_count   = r_res_hold;

endmodule

// ----- sv/recursive_lock_with_wait_queue_unit.sv -----
// Top level of the recursive lock unit with a FIFO wait queue.
//
// Requests arrive on the s_axis channel, one acquire or release per beat.
// Each request yields exactly one result beat on the m_axis channel with the
// status, an optional woken waiter id and the holder's recursion count.
// A request is handled in a capture step, which latches the beat, and an
// execute step, which decides, updates the lock and loads the result register;
// the head of the wait queue is read from the queue memory through a
// registered port. A new request is not accepted until the previous one has
// executed, so requests are handled one at a time.
// The result register lets the next request be captured while the previous
// result still waits; if the receiver stalls, the request holds in its
// execute step until the result register frees, and s_axis_tready stays low.
// Reset (synchronous, active low) frees the lock, clears the owner, count,
// queue pointers and waiter bitmap, and empties the result register. The
// queue memory needs no clearing pass: only entries pushed earlier are read.
module recursive_lock_with_wait_queue_unit #(
    parameter int THREAD_COUNT = 16,
    parameter int QUEUE_DEPTH  = 16,
    parameter int COUNT_BITS   = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // op [0], thread_id [4:1], zero pad [7:5]
    input  logic [rlwq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status [2:0], woken_valid [3], woken_thread [7:4], hold_count [15:8]
    output logic [rlwq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    rlwq_pkg::t_ctrl_cmd  cmd;
    rlwq_pkg::t_dp_status dp_status;

    logic [rlwq_pkg::STATUS_W-1:0] res_status;
    logic                          res_wvalid;
    logic [rlwq_pkg::TID_W-1:0]    res_wthread;
    logic [rlwq_pkg::HOLD_W-1:0]   res_hold;

    // Controller.
    rlwq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (cmd)
    );

    // Datapath.
    rlwq_dp #(
        .THREAD_COUNT (THREAD_COUNT),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .COUNT_BITS   (COUNT_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (dp_status),
        .i_op               (s_axis_tdata[0]),
        .i_tid              (s_axis_tdata[4:1]),
        .o_out_valid        (m_axis_tvalid),
        .i_out_ready        (m_axis_tready),
        .o_res_status       (res_status),
        .o_res_woken_valid  (res_wvalid),
        .o_res_woken_thread (res_wthread),
        .o_res_hold_count   (res_hold)
    );

    // Pack the result beat.
    assign m_axis_tdata = {res_hold, res_wthread, res_wvalid, res_status};

endmodule

// ----- sv/rlwq_checker.sv -----
// Port-level checker of the recursive lock unit and its bind.
`include "recursive_lock_with_wait_queue_unit_defines.svh"

module rlwq_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rlwq_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result beat holds its value.
    `RLWQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A woken waiter is only reported on a release.
    `RLWQ_ASSERT_NOW(a_wake_on_release, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[2:0] == rlwq_pkg::ST_RELEASED)

    // A wake frees the lock, so the reported count is zero.
    `RLWQ_ASSERT_NOW(a_wake_count_zero, m_axis_tvalid && m_axis_tdata[3], m_axis_tdata[15:8] == 8'd0)

    // Without a wake the woken id reads zero.
    `RLWQ_ASSERT_NOW(a_no_wake_id_zero, m_axis_tvalid && !m_axis_tdata[3], m_axis_tdata[7:4] == 4'd0)

    // A request accepted now cannot be followed by another in the next cycle.
    `RLWQ_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind recursive_lock_with_wait_queue_unit rlwq_checker u_rlwq_checker (.*);

// ----- tb/sv/tb_recursive_lock_with_wait_queue_unit.sv -----
// Self-checking stream testbench for the recursive lock unit with its FIFO wait queue.
`timescale 1ns / 1ps

module tb_recursive_lock_with_wait_queue_unit;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int THREADS      = 16;
    localparam int WAIT_SLOTS   = 16;
    localparam int RANDOM_BEATS = 1500;

    // One result beat, split into its fields.
    typedef struct packed {
        logic [rlwq_pkg::STATUS_W-1:0] status;
        logic                          woken_valid;
        logic [rlwq_pkg::TID_W-1:0]    woken_thread;
        logic [rlwq_pkg::HOLD_W-1:0]   hold_count;
    } t_lock_result;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    // op [0], thread_id [4:1], zero pad [7:5]
    logic [rlwq_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // status [2:0], woken_valid [3], woken_thread [7:4], hold_count [15:8]
    logic [rlwq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // Lock state as this bench believes it to be.
    logic                             lk_free = 1'b1;
    logic                             lk_owned = 1'b0;
    logic [rlwq_pkg::TID_W-1:0]       lk_owner = '0;
    logic [rlwq_pkg::HOLD_W-1:0]      lk_count = '0;
    logic [rlwq_pkg::TID_W-1:0]       wq_mem [WAIT_SLOTS];
    logic [rlwq_pkg::TID_W-1:0]       wq_head = '0;
    logic [rlwq_pkg::TID_W-1:0]       wq_tail = '0;
    logic [4:0]                       wq_fill = '0;
    logic [THREADS-1:0]               wq_waiting = '0;
    int                               last_woken = -1;

    t_lock_result                     pending_results[$];
    int                               cycle_cnt = 0;
    int                               fail_cnt = 0;
    int                               sent_cnt = 0;
    int                               checked_cnt = 0;
    int                               wake_cnt = 0;
    int                               status_seen [8];
    int                               stall_left = 0;
    bit                               src_idle_on = 1'b1;
    bit                               sink_idle_on = 1'b1;

    recursive_lock_with_wait_queue_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_cnt, pending_results.size());
        $display("** recursive_lock_with_wait_queue_unit: FAILED **");
        $finish;
    end

    // Applies one request to the lock state and returns the result it must produce.
    function automatic t_lock_result predict_lock_step(input logic op,
                                                       input logic [rlwq_pkg::TID_W-1:0] tid);
        t_lock_result res;
        res = '0;
        if (op == rlwq_pkg::OP_ACQUIRE) begin
            if (lk_owned && lk_owner == tid) begin
                // Recursive acquire saturates at the top of the count.
                if (lk_count == '1) begin
                    res.status = rlwq_pkg::ST_OVERFLOW;
                end else begin
                    lk_count   = lk_count + 1'b1;
                    res.status = rlwq_pkg::ST_GRANTED;
                end
            end else if (wq_waiting[tid]) begin
                res.status = rlwq_pkg::ST_DUP_WAIT;
            end else if (lk_free) begin
                lk_free    = 1'b0;
                lk_owned   = 1'b1;
                lk_owner   = tid;
                lk_count   = 8'd1;
                res.status = rlwq_pkg::ST_GRANTED;
                if (last_woken == int'(tid)) begin
                    last_woken = -1;
                end
            end else if (wq_fill >= WAIT_SLOTS) begin
                res.status = rlwq_pkg::ST_FULL;
            end else begin
                wq_mem[wq_tail] = tid;
                wq_tail         = wq_tail + 1'b1;
                wq_fill         = wq_fill + 1'b1;
                wq_waiting[tid] = 1'b1;
                res.status      = rlwq_pkg::ST_QUEUED;
            end
        end else begin
            if (!lk_owned || lk_owner != tid) begin
                res.status = rlwq_pkg::ST_NOT_HOLDER;
            end else if (lk_count <= 1) begin
                // Last release frees the lock and wakes the head waiter.
                lk_count = '0;
                lk_owned = 1'b0;
                lk_owner = '0;
                lk_free  = 1'b1;
                if (wq_fill > 0) begin
                    res.woken_valid  = 1'b1;
                    res.woken_thread = wq_mem[wq_head];
                    wq_waiting[wq_mem[wq_head]] = 1'b0;
                    last_woken = int'(wq_mem[wq_head]);
                    wq_head = wq_head + 1'b1;
                    wq_fill = wq_fill - 1'b1;
                end
                res.status = rlwq_pkg::ST_RELEASED;
            end else begin
                lk_count   = lk_count - 1'b1;
                res.status = rlwq_pkg::ST_RELEASED;
            end
        end
        res.hold_count = lk_count;
        return res;
    endfunction

    // Source idle length: mostly none, sometimes short, rarely long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!src_idle_on || r < 60) begin
            return 0;
        end
        if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Sends one request beat and records its expected result once accepted.
    task automatic send_request(input logic op, input logic [rlwq_pkg::TID_W-1:0] tid);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, tid, op};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_lock_step(op, tid));
        sent_cnt++;
    endtask

    // Brings the lock back to free with an empty wait queue.
    task automatic drain_lock();
        int pick;
        while (lk_owned || wq_fill != 0) begin
            if (lk_owned) begin
                send_request(rlwq_pkg::OP_RELEASE, lk_owner);
            end else begin
                pick = last_woken;
                for (int t = 0; t < THREADS && pick < 0; t++) begin
                    if (!wq_waiting[t]) begin
                        pick = t;
                    end
                end
                send_request(rlwq_pkg::OP_ACQUIRE, pick[rlwq_pkg::TID_W-1:0]);
            end
        end
    endtask

    // Result side: random stalls on tready.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (sink_idle_on && $urandom_range(0, 99) < 30) begin
            m_axis_tready <= 1'b0;
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30)
                                                     : $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_cnt++;
        end
    endtask

    // Compares each result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_lock_result exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("Result beat 0x%04h arrived with no request outstanding", m_axis_tdata);
                fail_cnt++;
            end else begin
                exp_res = pending_results.pop_front();
                check_field("status", int'(exp_res.status), int'(m_axis_tdata[2:0]));
                check_field("woken_valid", int'(exp_res.woken_valid), int'(m_axis_tdata[3]));
                check_field("woken_thread", int'(exp_res.woken_thread),
                            int'(m_axis_tdata[7:4]));
                check_field("hold_count", int'(exp_res.hold_count), int'(m_axis_tdata[15:8]));
                status_seen[exp_res.status]++;
                wake_cnt += exp_res.woken_valid;
                checked_cnt++;
            end
        end
    end

    // Plain grant, recursion and releases on a free lock, at both thread id extremes.
    task automatic test_recursion_basics();
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd0);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd0);
        send_request(rlwq_pkg::OP_RELEASE, 4'd0);
        send_request(rlwq_pkg::OP_RELEASE, 4'd0);
        send_request(rlwq_pkg::OP_RELEASE, 4'd0);
        send_request(rlwq_pkg::OP_RELEASE, 4'd15);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd15);
        send_request(rlwq_pkg::OP_RELEASE, 4'd0);
        send_request(rlwq_pkg::OP_RELEASE, 4'd15);
    endtask

    // Queuing, duplicate waiters, wakeup order and barging by another thread.
    task automatic test_waiters_and_barging();
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd15);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd3);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd7);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd3);
        send_request(rlwq_pkg::OP_RELEASE, 4'd5);
        send_request(rlwq_pkg::OP_RELEASE, 4'd15);
        // Still-queued thread asking while the lock is free counts as a duplicate.
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd7);
        // A third thread takes the lock ahead of the woken one.
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd9);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd3);
        send_request(rlwq_pkg::OP_RELEASE, 4'd9);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd7);
        drain_lock();
    endtask

    // Every other thread waits behind one holder, then the queue empties in order.
    task automatic test_queue_fill_and_drain();
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd0);
        for (int t = 1; t < THREADS; t++) begin
            send_request(rlwq_pkg::OP_ACQUIRE, t[rlwq_pkg::TID_W-1:0]);
        end
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd15);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd1);
        drain_lock();
    endtask

    // Recursion up to the top of the count, two requests past it, and the unwind.
    task automatic test_count_overflow();
        for (int n = 0; n < 255; n++) begin
            send_request(rlwq_pkg::OP_ACQUIRE, 4'd10);
            if (n == 100) begin
                send_request(rlwq_pkg::OP_ACQUIRE, 4'd4);
            end
        end
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd10);
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd10);
        send_request(rlwq_pkg::OP_RELEASE, 4'd4);
        for (int n = 0; n < 255; n++) begin
            send_request(rlwq_pkg::OP_RELEASE, 4'd10);
        end
        send_request(rlwq_pkg::OP_ACQUIRE, 4'd4);
        drain_lock();
    endtask

    // Mostly well-formed lock traffic with random threads, plus noise.
    task automatic test_random_traffic();
        int r;
        logic op;
        logic [rlwq_pkg::TID_W-1:0] tid;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            // Four phases with different idling on the two sides.
            if (n % (RANDOM_BEATS / 4) == 0) begin
                src_idle_on  = ((n / (RANDOM_BEATS / 4)) % 2) == 0;
                sink_idle_on = (n / (RANDOM_BEATS / 4)) < 2;
            end
            r = $urandom_range(0, 99);
            if (lk_owned && r < 35) begin
                op  = rlwq_pkg::OP_RELEASE;
                tid = lk_owner;
            end else if (lk_owned && r < 45) begin
                op  = rlwq_pkg::OP_ACQUIRE;
                tid = lk_owner;
            end else if (last_woken >= 0 && r < 60) begin
                op  = rlwq_pkg::OP_ACQUIRE;
                tid = last_woken[rlwq_pkg::TID_W-1:0];
            end else if (r < 88) begin
                op  = rlwq_pkg::OP_ACQUIRE;
                tid = rlwq_pkg::TID_W'($urandom_range(0, THREADS - 1));
            end else begin
                op  = 1'($urandom_range(0, 1));
                tid = rlwq_pkg::TID_W'($urandom_range(0, THREADS - 1));
            end
            send_request(op, tid);
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        drain_lock();
    endtask

    // Test sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_recursion_basics();
        test_waiters_and_barging();
        test_queue_fill_and_drain();
        test_count_overflow();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        $display("Sent %0d lock requests and checked %0d results, %0d of them with a wakeup.",
                 sent_cnt, checked_cnt, wake_cnt);
        $display("Status counts: granted %0d, queued %0d, released %0d, not holder %0d,",
                 status_seen[rlwq_pkg::ST_GRANTED], status_seen[rlwq_pkg::ST_QUEUED],
                 status_seen[rlwq_pkg::ST_RELEASED], status_seen[rlwq_pkg::ST_NOT_HOLDER],
                 " duplicate waiter %0d, count overflow %0d",
                 status_seen[rlwq_pkg::ST_DUP_WAIT], status_seen[rlwq_pkg::ST_OVERFLOW]);
        if (fail_cnt == 0) begin
            $display("** recursive_lock_with_wait_queue_unit: PASSED **");
        end else begin
            $display("** recursive_lock_with_wait_queue_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ----- recursive_lock_with_wait_queue_unit.f -----
+incdir+sv
sv/rlwq_pkg.sv
sv/rlwq_ctrl.sv
sv/rlwq_dp.sv
sv/recursive_lock_with_wait_queue_unit.sv
sv/rlwq_checker.sv
tb/sv/tb_recursive_lock_with_wait_queue_unit.sv
